### hw/rtl/tcfd_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the deframer.
// Used by tcfd_parser, tcfd_out_fifo and text_and_crc_frame_deframer_core.
// No dependencies.
package tcfd_pkg;

  localparam logic [7:0]  SOH_BYTE = 8'h01;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Header position codes: count of header bytes seen, SOH included
  localparam logic [3:0] HDR_TEXT    = 4'd0;
  localparam logic [3:0] HDR_ID_HI   = 4'd1;
  localparam logic [3:0] HDR_ID_LO   = 4'd2;
  localparam logic [3:0] HDR_LEN_HI  = 4'd3;
  localparam logic [3:0] HDR_LEN_LO  = 4'd4;
  localparam logic [3:0] HDR_CRC_B3  = 4'd5;
  localparam logic [3:0] HDR_CRC_B2  = 4'd6;
  localparam logic [3:0] HDR_CRC_B1  = 4'd7;
  localparam logic [3:0] HDR_CRC_B0  = 4'd8;

  // Output kinds
  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Packed result word: 105 field bits, padded to 14 bytes
  localparam int OUT_DATA_W = 112;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] frame_id;
    logic [15:0] frame_len;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;
    logic        crc_ok;
  } res_t;

  // Output queue status toward the input side
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Reflected CRC-32, one byte (eight shift steps of XOR logic)
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/text_and_crc_frame_deframer_core.sv
// Top level of the SOH-framed text/payload deframer with CRC-32 check.
// Instantiates tcfd_parser and tcfd_out_fifo; depends on tcfd_pkg.
//
// Usage:
//   Input stream (in_*): one received serial byte per request in
//   in_tdata[7:0]. Text bytes pass straight out; an SOH (0x01) opens a
//   9-byte header (SOH, id, length, CRC, big-endian) that produces no
//   output; the stated number of payload bytes then pass out with the
//   header fields attached, and the last one carries tlast, the computed
//   CRC-32 (reflected IEEE) and the check flag.
//   Output stream (out_*): one request per text or payload byte. tuser is
//   the kind (0 text, 1 payload), tlast marks the end of a frame.
// Timing:
//   Path from input request to out_tvalid: the input register, then the
//   parser step that writes the result queue. Throughput is one byte per
//   cycle while the queue has room; the byte-wide CRC update and the header
//   bookkeeping sit in the single parser stage.
// Reset (rst_n low, synchronous): text mode, CRC register all ones, the
//   input register and the 2-entry result queue empty.
// Stall: when out_tready is low results collect in the 2-entry queue;
//   once it is full the input register holds, and in_tready drops while
//   it is occupied. Header bytes still need a free queue slot to be taken.
module text_and_crc_frame_deframer_core
  import tcfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_byte, [23:8] frame_id, [39:24] frame_len,
  // [71:40] received_crc, [103:72] computed_crc, [104] crc_ok, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] out_kind
  output logic                  out_tlast   // frame_end
);

  logic       s1_v_r, s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       in_acc;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       head;
  fifo_stat_t fstat;
  logic       pop;

  // Input register: moves into the parser whenever the queue has room
  assign advance   = s1_v_r && !fstat.full;
  assign in_tready = !s1_v_r || !fstat.full;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
    end
  end

  tcfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .rx_byte   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign pop = out_tvalid && out_tready;

  tcfd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance && res_valid),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .stat      (fstat)
  );

  // Output packing
  assign out_tvalid = !fstat.empty;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.frame_end;
  assign out_tdata  = {7'd0, head.crc_ok, head.computed_crc, head.received_crc,
                       head.frame_len, head.frame_id, head.data_byte};

  // Checks
  a_end_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PAYLOAD)
    else $error("frame end on a text result");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[104] |-> out_tlast)
    else $error("crc_ok outside frame end");

  a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TEXT |-> out_tdata[104:8] == '0)
    else $error("text result carries header fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("queue not empty after reset");

endmodule

### hw/rtl/tcfd_parser.sv
// Frame parser: header/payload state, held header fields and running CRC.
// Produces zero or one result per stepped byte. Depends on tcfd_pkg.
module tcfd_parser
  import tcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic        in_pay_r, in_pay_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;

  logic [31:0] crc_upd;
  logic [15:0] cnt_inc;
  logic [31:0] computed;

  assign crc_upd  = crc32_byte(crc_r, rx_byte);
  assign cnt_inc  = cnt_r + 16'd1;
  assign computed = ~crc_upd;

  // Next state and result for one byte
  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    in_pay_nxt  = in_pay_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    hcrc_nxt    = hcrc_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    res_valid   = 1'b0;
    res         = '0;
    res.data_byte = rx_byte;

    if (in_pay_r) begin
      // payload byte
      crc_nxt          = crc_upd;
      cnt_nxt          = cnt_inc;
      res_valid        = 1'b1;
      res.kind         = KIND_PAYLOAD;
      res.frame_id     = id_r;
      res.frame_len    = len_r;
      res.received_crc = hcrc_r;
      if (cnt_inc == len_r) begin
        res.frame_end    = 1'b1;
        res.computed_crc = computed;
        res.crc_ok       = (computed != 32'd0) && (computed == hcrc_r);
        in_pay_nxt  = 1'b0;
        hdr_pos_nxt = HDR_TEXT;
        id_nxt      = '0;
        len_nxt     = '0;
        hcrc_nxt    = '0;
        cnt_nxt     = '0;
        crc_nxt     = CRC_INIT;
      end
    end else if (hdr_pos_r == HDR_TEXT) begin
      // text mode: SOH opens a header, anything else passes through
      if (rx_byte == SOH_BYTE) begin
        hdr_pos_nxt = HDR_ID_HI;
      end else begin
        res_valid = 1'b1;
        res.kind  = KIND_TEXT;
      end
    end else begin
      // header bytes, big-endian
      case (hdr_pos_r)
        HDR_ID_HI:  id_nxt   = {rx_byte, id_r[7:0]};
        HDR_ID_LO:  id_nxt   = {id_r[15:8], rx_byte};
        HDR_LEN_HI: len_nxt  = {rx_byte, len_r[7:0]};
        HDR_LEN_LO: len_nxt  = {len_r[15:8], rx_byte};
        HDR_CRC_B3: hcrc_nxt = {rx_byte, hcrc_r[23:0]};
        HDR_CRC_B2: hcrc_nxt = {hcrc_r[31:24], rx_byte, hcrc_r[15:0]};
        HDR_CRC_B1: hcrc_nxt = {hcrc_r[31:16], rx_byte, hcrc_r[7:0]};
        default:    hcrc_nxt = {hcrc_r[31:8], rx_byte};
      endcase
      hdr_pos_nxt = hdr_pos_r + 4'd1;
      if (hdr_pos_r >= HDR_CRC_B0) begin
        hdr_pos_nxt = HDR_TEXT;
        cnt_nxt     = '0;
        crc_nxt     = CRC_INIT;
        if (len_nxt != 16'd0) begin
          in_pay_nxt = 1'b1;
        end else begin
          // empty frame is dropped silently
          id_nxt   = '0;
          hcrc_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r <= HDR_TEXT;
      in_pay_r  <= 1'b0;
      id_r      <= '0;
      len_r     <= '0;
      hcrc_r    <= '0;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
    end else if (step_en) begin
      hdr_pos_r <= hdr_pos_nxt;
      in_pay_r  <= in_pay_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      hcrc_r    <= hcrc_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
    end
  end

endmodule

### hw/rtl/tcfd_out_fifo.sv
// Two-entry result queue that decouples the parser from the output stall.
// Depends on tcfd_pkg.
module tcfd_out_fifo
  import tcfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_t       push_data,
  input  logic       pop,
  output res_t       head,
  output fifo_stat_t stat
);

  res_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head       = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
